### hdl/ordered_array_table_defines.svh
// ----------------------------------------------------------------------------
// Ordered array table: assertion macros
// Shared helpers for the concurrent checks at the end of the top RTL module.
// ----------------------------------------------------------------------------
`ifndef ORDERED_ARRAY_TABLE_DEFINES_SVH
`define ORDERED_ARRAY_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on clk and off during reset.
`define OAT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and off during reset.
`define OAT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/oat_pkg.sv
// ----------------------------------------------------------------------------
// Ordered array table package
// Widths, request and status codes, and cell modes shared by the modules.
// ----------------------------------------------------------------------------
package oat_pkg;

	// Default store depth and the fixed word width.
	localparam int DEPTH_DEF = 32;
	localparam int WORD_BITS = 32;

	// Field widths of the stream beats and the limit register.
	localparam int REQ_W   = 3;
	localparam int POS_W   = 6;
	localparam int LIMIT_W = 6;
	localparam int STAT_W  = 2;
	localparam int HPOS_W  = 5;
	localparam int ECNT_W  = 6;

	// Packed payload widths, rounded up to whole bytes.
	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 48;

	// Limit register value after reset.
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd32;

	// Width of one group of the find priority encoder.
	localparam int GROUP = 8;
	localparam int GLOW_W = 3;

	typedef enum logic [REQ_W-1:0] {
		REQ_APPEND = 3'd0,
		REQ_INSERT = 3'd1,
		REQ_EDIT   = 3'd2,
		REQ_DELETE = 3'd3,
		REQ_READ   = 3'd4,
		REQ_FIND   = 3'd5
	} req_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 2'd0,
		ST_BAD_INDEX = 2'd1,
		ST_FULL      = 2'd2
	} status_t;

	// What every cell does at the edge of an accepted beat.
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_WRITE,
		CELL_SHIFT_UP,
		CELL_SHIFT_DOWN
	} cell_mode_t;

endpackage

### hdl/oat_cell.sv
// ----------------------------------------------------------------------------
// Ordered array table: storage cell
// Holds one entry, takes a new word or a neighbor's entry, and compares its
// entry with the search word.
// ----------------------------------------------------------------------------
module oat_cell #(
	parameter int DEPTH = oat_pkg::DEPTH_DEF,
	parameter int IDX   = 0
) (
	input  logic                          clk,
	input  logic                          en,
	input  oat_pkg::cell_mode_t           mode,
	input  logic [$clog2(DEPTH)-1:0]      target,
	input  logic [$clog2(DEPTH+1)-1:0]    count,
	input  logic [oat_pkg::WORD_BITS-1:0] word,
	input  logic [oat_pkg::WORD_BITS-1:0] left_word,
	input  logic [oat_pkg::WORD_BITS-1:0] right_word,
	output logic [oat_pkg::WORD_BITS-1:0] entry,
	output logic                          match
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH+1);
	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);
	localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(IDX);

	logic [oat_pkg::WORD_BITS-1:0] entry_q;

	// Entry update: write at the target, or shift with the neighbors.
	always_ff @(posedge clk) begin
		if (en) begin
			case (mode)
				oat_pkg::CELL_WRITE: begin
					if (MY_IDX == target) entry_q <= word;
				end
				oat_pkg::CELL_SHIFT_UP: begin
					if (MY_IDX == target) entry_q <= word;
					else if (MY_IDX > target) entry_q <= left_word;
				end
				oat_pkg::CELL_SHIFT_DOWN: begin
					if (MY_IDX >= target) entry_q <= right_word;
				end
				default: begin
					entry_q <= entry_q;
				end
			endcase
		end
	end

	// Only entries below the count take part in a search.
	assign match = (MY_CNT < count) && (entry_q == word);
	assign entry = entry_q;

endmodule

### hdl/oat_group.sv
// ----------------------------------------------------------------------------
// Ordered array table: find group encoder
// Reduces up to eight match flags to an any flag and the lowest hit offset.
// ----------------------------------------------------------------------------
module oat_group #(
	parameter int GW = oat_pkg::GROUP
) (
	input  logic [GW-1:0]                 match,
	output logic                          any,
	output logic [oat_pkg::GLOW_W-1:0]    low
);

	// Lowest set flag wins, so scan from the top down.
	always_comb begin
		low = '0;
		for (int k = GW - 1; k >= 0; k--) begin
			if (match[k]) low = oat_pkg::GLOW_W'(k);
		end
	end

	assign any = |match;

endmodule

### hdl/ordered_array_table.sv
// ----------------------------------------------------------------------------
// Ordered array table
// Positional list of signed words kept in a row of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
// A request beat on the s_ channel carries the request code in s_tuser and
// the position and data word in s_tdata. Each accepted beat yields exactly
// one result beat on the m_ channel with status, read word, find result,
// entry count and the empty and full flags.
// After a request is accepted, the cells update and compare in the accept
// cycle, the find groups are registered in stage one, and the group priority
// feeds the output register, from which the result beat leaves.
// One request is taken in every cycle that the result channel does not stall;
// all entries shift together in the accept cycle for insert and delete, so the rate is one beat a cycle.
// When the receiver holds m_tready low with a beat waiting, the whole pipe
// holds and s_tready drops until that beat is taken.
// Reset empties the list and sets the capacity limit to 32; entry contents
// are undefined until written. The limit is written through cfg_we and
// cfg_wdata; the user must write it only while no request is in flight, which
// the block itself does not enforce. 0 acts as 1 and values above DEPTH act as DEPTH.
// ----------------------------------------------------------------------------
`include "ordered_array_table_defines.svh"

module ordered_array_table #(
	parameter int DEPTH = oat_pkg::DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Limit register write port.
	input  logic                          cfg_we,
	input  logic [oat_pkg::LIMIT_W-1:0]   cfg_wdata,
	// Request channel.
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// s_tdata: position [5:0], data_word [37:6], zero fill [39:38].
	input  logic [oat_pkg::S_TDATA_W-1:0] s_tdata,
	// s_tuser: req_type [2:0].
	input  logic [oat_pkg::REQ_W-1:0]     s_tuser,
	// Result channel.
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// m_tdata: status [1:0], read_word [33:2], hit [34], hit_position [39:35],
	// entry_count [45:40], empty flag [46], full flag [47].
	output logic [oat_pkg::M_TDATA_W-1:0] m_tdata
);

	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH+1);
	localparam int PW     = (CNT_W > oat_pkg::POS_W) ? CNT_W : oat_pkg::POS_W;
	localparam int NGRP   = (DEPTH + oat_pkg::GROUP - 1) / oat_pkg::GROUP;
	localparam int GIDX_W = (NGRP > 1) ? $clog2(NGRP) : 1;
	localparam int HW     = GIDX_W + oat_pkg::GLOW_W;
	localparam int WB     = oat_pkg::WORD_BITS;

	// Control state.
	logic [oat_pkg::LIMIT_W-1:0] limit_q;
	logic [CNT_W-1:0]            count_q;
	logic                        v_s1_q;
	logic                        m_tvalid_q;

	// Request fields.
	oat_pkg::req_t               req;
	logic [oat_pkg::POS_W-1:0]   position;
	logic [WB-1:0]               data_word;

	// Decode of the accepted beat.
	logic                        accept;
	logic                        adv;
	logic [PW-1:0]               pos_x;
	logic [PW-1:0]               cnt_x;
	logic [PW-1:0]               eff_x;
	logic                        full_now;
	logic                        in_range;
	oat_pkg::cell_mode_t         mode;
	logic [IDX_W-1:0]            target;
	oat_pkg::status_t            status;
	logic [CNT_W-1:0]            cnt_next;
	logic                        full_next;
	logic                        rd_en;
	logic                        is_find;

	// Cell row.
	logic [WB-1:0]               entry_vec [DEPTH];
	logic [DEPTH-1:0]            match_vec;
	logic [NGRP-1:0]             gany;
	logic [oat_pkg::GLOW_W-1:0]  glow [NGRP];

	// Stage one.
	oat_pkg::status_t            status_s1;
	logic [WB-1:0]               rd_s1;
	logic [NGRP-1:0]             gany_s1;
	logic [oat_pkg::GLOW_W-1:0]  glow_s1 [NGRP];
	logic [CNT_W-1:0]            cnt_s1;
	logic                        full_s1;

	// Group priority and output register.
	logic                        hit;
	logic [HW-1:0]               hit_idx;
	oat_pkg::status_t            status_q;
	logic [WB-1:0]               rd_q;
	logic                        hit_q;
	logic [HW-1:0]               hit_idx_q;
	logic [CNT_W-1:0]            cnt_q;
	logic                        full_q;

	assign req       = oat_pkg::req_t'(s_tuser);
	assign position  = s_tdata[oat_pkg::POS_W-1:0];
	assign data_word = s_tdata[oat_pkg::POS_W +: WB];

	// The pipe moves unless a result beat waits on a stalled receiver.
	assign adv      = !(m_tvalid_q && !m_tready);
	assign s_tready = adv;
	assign accept   = s_tvalid && adv;

	// Effective limit, full flag and index check.
	always_comb begin
		pos_x = PW'(position);
		cnt_x = PW'(count_q);
		if (limit_q == '0) eff_x = PW'(1);
		else if (PW'(limit_q) > PW'(DEPTH)) eff_x = PW'(DEPTH);
		else eff_x = PW'(limit_q);
		full_now = cnt_x >= eff_x;
		in_range = pos_x < cnt_x;
	end

	// Request decode into a cell command and a status.
	always_comb begin
		mode     = oat_pkg::CELL_HOLD;
		target   = IDX_W'(pos_x);
		status   = oat_pkg::ST_OK;
		cnt_next = count_q;
		rd_en    = 1'b0;
		is_find  = 1'b0;
		case (req)
			oat_pkg::REQ_APPEND, oat_pkg::REQ_INSERT: begin
				if (full_now) begin
					status = oat_pkg::ST_FULL;
				end else begin
					if (req == oat_pkg::REQ_INSERT && in_range) begin
						mode = oat_pkg::CELL_SHIFT_UP;
					end else begin
						mode   = oat_pkg::CELL_WRITE;
						target = IDX_W'(cnt_x);
					end
					cnt_next = count_q + 1'b1;
				end
			end
			oat_pkg::REQ_EDIT: begin
				if (in_range) mode = oat_pkg::CELL_WRITE;
				else status = oat_pkg::ST_BAD_INDEX;
			end
			oat_pkg::REQ_DELETE: begin
				if (in_range) begin
					mode     = oat_pkg::CELL_SHIFT_DOWN;
					cnt_next = count_q - 1'b1;
				end else begin
					status = oat_pkg::ST_BAD_INDEX;
				end
			end
			oat_pkg::REQ_READ: begin
				if (in_range) rd_en = 1'b1;
				else status = oat_pkg::ST_BAD_INDEX;
			end
			oat_pkg::REQ_FIND: begin
				is_find = 1'b1;
			end
			default: begin
				mode = oat_pkg::CELL_HOLD;
			end
		endcase
		full_next = PW'(cnt_next) >= eff_x;
	end

	// Row of cells, each wired to its lower and upper neighbor.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [WB-1:0] left_w;
		logic [WB-1:0] right_w;
		if (i == 0) begin : g_first
			assign left_w = entry_vec[i];
		end else begin : g_mid_l
			assign left_w = entry_vec[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_w = entry_vec[i];
		end else begin : g_mid_r
			assign right_w = entry_vec[i+1];
		end
		oat_cell #(
			.DEPTH (DEPTH),
			.IDX   (i)
		) u_cell (
			.clk        (clk),
			.en         (accept),
			.mode       (mode),
			.target     (target),
			.count      (count_q),
			.word       (data_word),
			.left_word  (left_w),
			.right_word (right_w),
			.entry      (entry_vec[i]),
			.match      (match_vec[i])
		);
	end

	// Find encoders, one per group of up to eight cells.
	for (genvar g = 0; g < NGRP; g++) begin : g_grp
		localparam int GW = (DEPTH - g * oat_pkg::GROUP < oat_pkg::GROUP) ?
			(DEPTH - g * oat_pkg::GROUP) : oat_pkg::GROUP;
		oat_group #(
			.GW (GW)
		) u_group (
			.match (match_vec[g * oat_pkg::GROUP +: GW]),
			.any   (gany[g]),
			.low   (glow[g])
		);
	end

	// Control registers: limit, count and stage valids.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q    <= oat_pkg::LIMIT_RESET;
			count_q    <= '0;
			v_s1_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_we) limit_q <= cfg_wdata;
			if (accept) count_q <= cnt_next;
			if (adv) begin
				v_s1_q     <= accept;
				m_tvalid_q <= v_s1_q;
			end
		end
	end

	// Stage one payload.
	always_ff @(posedge clk) begin
		if (adv) begin
			status_s1 <= status;
			rd_s1     <= rd_en ? entry_vec[IDX_W'(pos_x)] : '0;
			gany_s1   <= is_find ? gany : '0;
			glow_s1   <= glow;
			cnt_s1    <= cnt_next;
			full_s1   <= full_next;
		end
	end

	// The lowest group with a match gives the hit position.
	always_comb begin
		hit     = 1'b0;
		hit_idx = '0;
		for (int g = NGRP - 1; g >= 0; g--) begin
			if (gany_s1[g]) begin
				hit     = 1'b1;
				hit_idx = {GIDX_W'(g), glow_s1[g]};
			end
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (adv) begin
			status_q  <= status_s1;
			rd_q      <= rd_s1;
			hit_q     <= hit;
			hit_idx_q <= hit_idx;
			cnt_q     <= cnt_s1;
			full_q    <= full_s1;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {full_q, (cnt_q == '0), oat_pkg::ECNT_W'(cnt_q),
		oat_pkg::HPOS_W'(hit_idx_q), hit_q, rd_q, status_q};

	// Checks on the list bookkeeping.
	`OAT_ASSERT_NOW(a_count_bound, 1'b1, PW'(count_q) <= PW'(DEPTH),
		"entry count above store depth")
	`OAT_ASSERT_NEXT(a_full_keeps_count,
		accept && (req == oat_pkg::REQ_APPEND || req == oat_pkg::REQ_INSERT) && full_now,
		$stable(count_q), "refused append or insert changed the count")
	`OAT_ASSERT_NEXT(a_delete_count,
		accept && req == oat_pkg::REQ_DELETE && in_range,
		count_q == $past(count_q) - 1'b1, "delete did not drop the count by one")
	`OAT_ASSERT_NOW(a_hit_below_count, m_tvalid_q && hit_q,
		PW'(hit_idx_q) < PW'(cnt_q), "find hit at or past the entry count")

endmodule

### bench/tb_ordered_array_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered array table testbench
// Drives request beats with random gaps against a receiver that stalls at
// random, predicts every result beat from a private copy of the list and the
// capacity limit, and compares each result field by field in order.
// ----------------------------------------------------------------------------
module tb_ordered_array_table;
	import oat_pkg::*;

	localparam int HALF_PERIOD      = 5;
	localparam int WATCHDOG_LIMIT   = 2000;
	localparam int RANDOM_PER_PHASE = 100;
	localparam int TREND_BLOCK      = 50;
	localparam int MAX_PRINTED      = 40;

	// Request codes that the block has no operation for.
	localparam logic [REQ_W-1:0] REQ_UNUSED_6 = 3'd6;
	localparam logic [REQ_W-1:0] REQ_UNUSED_7 = 3'd7;

	// Direction the random mix pushes the entry count.
	typedef enum int {
		TREND_GROW,
		TREND_SHRINK,
		TREND_MIXED
	} trend_t;

	// One predicted result beat.
	typedef struct packed {
		status_t              status;
		logic [WORD_BITS-1:0] read_word;
		logic                 hit;
		logic [HPOS_W-1:0]    hit_position;
		logic [ECNT_W-1:0]    entry_count;
		logic                 no_entries;
		logic                 is_full;
	} answer_t;

	// Private copy of the list; predicts and checks the result beats.
	class table_scoreboard;
		logic [WORD_BITS-1:0] rows [DEPTH_DEF];
		int unsigned          fill;
		logic [LIMIT_W-1:0]   limit_reg;
		answer_t              awaited_answers [$];
		int                   errors;
		int                   answers_checked;
		int                   requests_noted;
		int                   full_refusals;
		int                   bad_indices;
		int                   find_hits;

		function void reset_state();
			fill = 0;
			limit_reg = LIMIT_RESET;
			foreach (rows[i])
				rows[i] = '0;
		endfunction

		// The limit register saturates into 1..DEPTH.
		function int unsigned usable();
			if (limit_reg == 0)
				return 1;
			if (limit_reg > DEPTH_DEF)
				return DEPTH_DEF;
			return limit_reg;
		endfunction

		function int pending();
			return awaited_answers.size();
		endfunction

		function void set_limit(logic [LIMIT_W-1:0] value);
			limit_reg = value;
		endfunction

		// Applies one accepted request and queues the answer it must produce.
		function void apply_request(logic [REQ_W-1:0] op, logic [POS_W-1:0] pos,
				logic [WORD_BITS-1:0] word);
			answer_t     a;
			int unsigned i;
			bit          was_full;
			a = '0;
			a.status = ST_OK;
			was_full = fill >= usable();
			requests_noted++;
			case (op)
				REQ_APPEND, REQ_INSERT: begin
					if (was_full || fill >= DEPTH_DEF) begin
						a.status = ST_FULL;
					end else begin
						if (op == REQ_INSERT && pos < fill) begin
							for (i = fill; i > pos; i--)
								rows[i] = rows[i - 1];
							rows[pos] = word;
						end else begin
							rows[fill] = word;
						end
						fill++;
					end
				end
				REQ_EDIT: begin
					if (pos >= fill)
						a.status = ST_BAD_INDEX;
					else
						rows[pos] = word;
				end
				REQ_DELETE: begin
					if (pos >= fill) begin
						a.status = ST_BAD_INDEX;
					end else begin
						for (i = pos; i + 1 < fill; i++)
							rows[i] = rows[i + 1];
						fill--;
					end
				end
				REQ_READ: begin
					if (pos >= fill)
						a.status = ST_BAD_INDEX;
					else
						a.read_word = rows[pos];
				end
				REQ_FIND: begin
					for (i = 0; i < fill; i++) begin
						if (rows[i] == word) begin
							a.hit = 1'b1;
							a.hit_position = i[HPOS_W-1:0];
							break;
						end
					end
				end
				default: begin
				end
			endcase
			a.entry_count = fill[ECNT_W-1:0];
			a.no_entries = (fill == 0);
			a.is_full = (fill >= usable());
			if (a.status == ST_FULL)
				full_refusals++;
			if (a.status == ST_BAD_INDEX)
				bad_indices++;
			if (a.hit)
				find_hits++;
			awaited_answers.push_back(a);
		endfunction

		task report(string what, logic [M_TDATA_W-1:0] want, logic [M_TDATA_W-1:0] got);
			if (errors < MAX_PRINTED)
				$display("[%0t] mismatch on %s: expected %h, got %h", $realtime, what, want, got);
			errors++;
		endtask

		// Compares one result beat with the oldest waiting answer.
		task check_result(logic [M_TDATA_W-1:0] beat);
			answer_t want;
			answers_checked++;
			if (awaited_answers.size() == 0) begin
				report("result beat with no request waiting", '0, beat);
				return;
			end
			want = awaited_answers.pop_front();
			if (beat[1:0] !== want.status)
				report("status", want.status, beat[1:0]);
			if (beat[33:2] !== want.read_word)
				report("read_word", want.read_word, beat[33:2]);
			if (beat[34] !== want.hit)
				report("hit", want.hit, beat[34]);
			if (beat[39:35] !== want.hit_position)
				report("hit_position", want.hit_position, beat[39:35]);
			if (beat[45:40] !== want.entry_count)
				report("entry_count", want.entry_count, beat[45:40]);
			if (beat[46] !== want.no_entries)
				report("empty flag", want.no_entries, beat[46]);
			if (beat[47] !== want.is_full)
				report("is_full_flag", want.is_full, beat[47]);
		endtask
	endclass

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [LIMIT_W-1:0]    cfg_wdata = '0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata   = '0;
	logic [REQ_W-1:0]      s_tuser   = '0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [M_TDATA_W-1:0]  m_tdata;

	table_scoreboard sb;
	bit              quiet = 1'b0;
	int              stall_left = 0;
	int              idle_cycles = 0;
	int              limit_writes = 0;

	ordered_array_table dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// Receiver: mostly ready, with short stalls and the odd long one.
	always @(negedge clk) begin
		if (quiet) begin
			m_tready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left = stall_left - 1;
			m_tready <= 1'b0;
		end else if ($urandom_range(0, 99) < 70) begin
			m_tready <= 1'b1;
		end else begin
			if ($urandom_range(0, 4) == 0)
				stall_left = $urandom_range(8, 40) - 1;
			else
				stall_left = $urandom_range(1, 3) - 1;
			m_tready <= 1'b0;
		end
	end

	// Every accepted result beat goes to the scoreboard.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata);
	end

	// Watchdog on cycles without any beat moving.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles = 0;
		else
			idle_cycles = idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("[%0t] no beat moved for %0d cycles", $realtime, WATCHDOG_LIMIT);
			$display("tb: failure");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Extremes, a small range that makes duplicates, or anything.
	function automatic logic [WORD_BITS-1:0] pick_word();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10) begin
			case ($urandom_range(0, 3))
				0: return 32'h8000_0000;
				1: return 32'h7FFF_FFFF;
				2: return 32'h0000_0000;
				default: return 32'hFFFF_FFFF;
			endcase
		end
		if (r < 35)
			return $urandom_range(0, 7);
		return $urandom();
	endfunction

	function automatic logic [POS_W-1:0] pick_position();
		if ($urandom_range(0, 3) != 0)
			return POS_W'($urandom_range(0, sb.fill));
		return POS_W'($urandom_range(0, 63));
	endfunction

	function automatic logic [REQ_W-1:0] pick_op(trend_t trend);
		int r;
		int w_app;
		int w_ins;
		int w_edit;
		int w_del;
		int w_rd;
		case (trend)
			TREND_GROW: begin
				w_app = 25; w_ins = 30; w_edit = 10; w_del = 8;  w_rd = 12;
			end
			TREND_SHRINK: begin
				w_app = 8;  w_ins = 10; w_edit = 10; w_del = 40; w_rd = 15;
			end
			default: begin
				w_app = 15; w_ins = 18; w_edit = 14; w_del = 18; w_rd = 16;
			end
		endcase
		r = $urandom_range(0, 99);
		if (r < w_app)
			return REQ_APPEND;
		r -= w_app;
		if (r < w_ins)
			return REQ_INSERT;
		r -= w_ins;
		if (r < w_edit)
			return REQ_EDIT;
		r -= w_edit;
		if (r < w_del)
			return REQ_DELETE;
		r -= w_del;
		if (r < w_rd)
			return REQ_READ;
		if ($urandom_range(0, 31) == 0)
			return $urandom_range(0, 1) ? REQ_UNUSED_6 : REQ_UNUSED_7;
		return REQ_FIND;
	endfunction

	function automatic trend_t pick_trend();
		case ($urandom_range(0, 2))
			0: return TREND_GROW;
			1: return TREND_SHRINK;
			default: return TREND_MIXED;
		endcase
	endfunction

	// Presents one request beat, waits for it to be taken, then idles for a random gap that may be zero.
	task automatic send_request(logic [REQ_W-1:0] op, logic [POS_W-1:0] pos,
			logic [WORD_BITS-1:0] word);
		int gap;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {2'b00, word, pos};
		do
			@(posedge clk);
		while (!s_tready);
		sb.apply_request(op, pos, word);
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1)
				@(negedge clk);
		end
	endtask

	// Stops sending and waits until every result beat has come back.
	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4)
			@(posedge clk);
	endtask

	task automatic write_limit(logic [LIMIT_W-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		sb.set_limit(value);
		limit_writes++;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Empty-list errors, both word extremes, insert past the end, duplicates
	// for find, deletes at both ends and the unused request codes.
	task automatic run_directed();
		send_request(REQ_READ,     6'd0,  32'h0000_0000);
		send_request(REQ_DELETE,   6'd0,  32'h0000_0000);
		send_request(REQ_EDIT,     6'd63, 32'hFFFF_FFFF);
		send_request(REQ_FIND,     6'd0,  32'h0000_0000);
		send_request(REQ_INSERT,   6'd63, 32'h7FFF_FFFF);
		send_request(REQ_APPEND,   6'd0,  32'h8000_0000);
		send_request(REQ_INSERT,   6'd0,  32'h0000_0000);
		send_request(REQ_INSERT,   6'd1,  32'hFFFF_FFFF);
		send_request(REQ_INSERT,   6'd4,  32'h0000_0005);
		send_request(REQ_READ,     6'd0,  32'h0000_0000);
		send_request(REQ_READ,     6'd4,  32'h0000_0000);
		send_request(REQ_READ,     6'd5,  32'h0000_0000);
		send_request(REQ_READ,     6'd63, 32'h0000_0000);
		send_request(REQ_EDIT,     6'd2,  32'h0000_0000);
		send_request(REQ_FIND,     6'd0,  32'h0000_0000);
		send_request(REQ_FIND,     6'd0,  32'h8000_0000);
		send_request(REQ_FIND,     6'd0,  32'h0000_0007);
		send_request(REQ_DELETE,   6'd0,  32'h0000_0000);
		send_request(REQ_DELETE,   6'd3,  32'h0000_0000);
		send_request(REQ_DELETE,   6'd3,  32'h0000_0000);
		send_request(REQ_UNUSED_6, 6'd1,  32'h1234_5678);
		send_request(REQ_UNUSED_7, 6'd2,  32'hFFFF_FFFF);
		send_request(REQ_FIND,     6'd0,  32'hFFFF_FFFF);
		send_request(REQ_EDIT,     6'd0,  32'h5555_5555);
		send_request(REQ_READ,     6'd0,  32'h0000_0000);
	endtask

	// Random requests in blocks that each lean toward growing, shrinking or neither.
	task automatic run_random(int count, trend_t first);
		trend_t               trend;
		logic [REQ_W-1:0]     op;
		logic [POS_W-1:0]     pos;
		logic [WORD_BITS-1:0] word;
		trend = first;
		for (int k = 0; k < count; k++) begin
			if (k % TREND_BLOCK == 0) begin
				if (k > 0)
					trend = pick_trend();
				quiet = ($urandom_range(0, 4) == 0);
			end
			op = pick_op(trend);
			pos = pick_position();
			if (op == REQ_FIND && sb.fill > 0 && $urandom_range(0, 9) < 6)
				word = sb.rows[$urandom_range(0, sb.fill - 1)];
			else
				word = pick_word();
			send_request(op, pos, word);
		end
		quiet = 1'b0;
	endtask

	initial begin
		logic [LIMIT_W-1:0] limit_plan [10];
		limit_plan = '{6'd63, 6'd4, 6'd0, 6'd1, 6'd32, 6'd12, 6'd33, 6'd31, 6'd2, 6'd20};
		sb = new;
		sb.reset_state();

		// Reset is held at start and released away from the rising edge.
		repeat (3)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		run_directed();

		// The first phase grows the list so that the next, lower limit
		// lands below the count.
		foreach (limit_plan[p]) begin
			settle();
			write_limit(limit_plan[p]);
			run_random(RANDOM_PER_PHASE, (p == 0) ? TREND_GROW : pick_trend());
		end

		settle();
		repeat (8)
			@(posedge clk);

		$display("Sent %0d requests across %0d limit settings; checked %0d result beats.",
			sb.requests_noted, limit_writes, sb.answers_checked);
		$display("Covered %0d store-full refusals, %0d bad indices and %0d find hits.",
			sb.full_refusals, sb.bad_indices, sb.find_hits);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

### filelist.f
+incdir+hdl
hdl/oat_pkg.sv
hdl/oat_cell.sv
hdl/oat_group.sv
hdl/ordered_array_table.sv
bench/tb_ordered_array_table.sv
